>>> src/rcdg_pkg.sv
// Package for the RGB565 crop, decimate and grayscale core.
// Holds register map codes, reset values, widths and shared structs.
// No dependencies.
package rcdg_pkg;

    // Position counter width, range 8 to 14
    localparam int COORD_BITS = 11;
    // Width for position / window arithmetic; covers COORD_BITS+1 and origin+size
    localparam int CALC_BITS  = 16;

    localparam int FW_BITS    = 12;   // frame_width
    localparam int ORG_BITS   = 11;   // crop_left, crop_top
    localparam int SIZE_BITS  = 12;   // crop_width, crop_height

    localparam int PADDR_BITS = 5;
    localparam int PDATA_BITS = 32;

    // register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_FRAME_WIDTH = 3'd0;
    localparam logic [2:0] REG_CROP_LEFT   = 3'd1;
    localparam logic [2:0] REG_CROP_TOP    = 3'd2;
    localparam logic [2:0] REG_CROP_WIDTH  = 3'd3;
    localparam logic [2:0] REG_CROP_HEIGHT = 3'd4;

    localparam logic [FW_BITS-1:0]   RST_FRAME_WIDTH = 12'd240;
    localparam logic [ORG_BITS-1:0]  RST_CROP_LEFT   = 11'd56;
    localparam logic [ORG_BITS-1:0]  RST_CROP_TOP    = 11'd56;
    localparam logic [SIZE_BITS-1:0] RST_CROP_WIDTH  = 12'd128;
    localparam logic [SIZE_BITS-1:0] RST_CROP_HEIGHT = 12'd128;

    typedef struct packed {
        logic [FW_BITS-1:0]   frame_width;
        logic [ORG_BITS-1:0]  crop_left;
        logic [ORG_BITS-1:0]  crop_top;
        logic [SIZE_BITS-1:0] crop_width;
        logic [SIZE_BITS-1:0] crop_height;
    } cfg_t;

    typedef struct packed {
        logic keep;
        logic last;
    } win_t;

endpackage

>>> src/rcdg_cfg_regs.sv
// APB-style configuration register file for the crop core.
// Depends on rcdg_pkg (register codes, reset values, cfg_t).
// Holds frame width and crop window registers.
module rcdg_cfg_regs
    import rcdg_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [PDATA_BITS-1:0] pwdata,
    output logic [PDATA_BITS-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_BITS-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_FRAME_WIDTH: cfg_next.frame_width = pwdata[FW_BITS-1:0];
                REG_CROP_LEFT:   cfg_next.crop_left   = pwdata[ORG_BITS-1:0];
                REG_CROP_TOP:    cfg_next.crop_top    = pwdata[ORG_BITS-1:0];
                REG_CROP_WIDTH:  cfg_next.crop_width  = pwdata[SIZE_BITS-1:0];
                REG_CROP_HEIGHT: cfg_next.crop_height = pwdata[SIZE_BITS-1:0];
                default: ;  // unmapped: ignored
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_width <= RST_FRAME_WIDTH;
            cfg_reg.crop_left   <= RST_CROP_LEFT;
            cfg_reg.crop_top    <= RST_CROP_TOP;
            cfg_reg.crop_width  <= RST_CROP_WIDTH;
            cfg_reg.crop_height <= RST_CROP_HEIGHT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_FRAME_WIDTH: prdata = PDATA_BITS'(cfg_reg.frame_width);
            REG_CROP_LEFT:   prdata = PDATA_BITS'(cfg_reg.crop_left);
            REG_CROP_TOP:    prdata = PDATA_BITS'(cfg_reg.crop_top);
            REG_CROP_WIDTH:  prdata = PDATA_BITS'(cfg_reg.crop_width);
            REG_CROP_HEIGHT: prdata = PDATA_BITS'(cfg_reg.crop_height);
            default:         prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

>>> src/rcdg_window.sv
// Raster position tracker and crop/decimation window decision.
// Depends on rcdg_pkg (cfg_t, win_t, COORD_BITS, CALC_BITS).
// Position advances on each pixel that leaves the input register.
module rcdg_window
    import rcdg_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  cfg_t cfg,
    input  logic advance,
    input  logic frame_start,
    output win_t win
);

    logic [COORD_BITS-1:0] col_reg, col_next;
    logic [COORD_BITS-1:0] row_reg, row_next;
    logic [COORD_BITS-1:0] col, row;
    logic [CALC_BITS-1:0]  col_inc;
    logic [CALC_BITS-1:0]  col_w, row_w;
    logic [CALC_BITS-1:0]  left_w, top_w, cw_w, ch_w;
    logic [CALC_BITS-1:0]  col_off, row_off;
    logic [CALC_BITS-1:0]  col_lastpos, row_lastpos;
    logic                  col_keep, row_keep, col_last, row_last;
    logic                  line_end;

    // frame start forces the pixel carrying it to the origin
    assign col = frame_start ? '0 : col_reg;
    assign row = frame_start ? '0 : row_reg;

    assign col_w  = CALC_BITS'(col);
    assign row_w  = CALC_BITS'(row);
    assign left_w = CALC_BITS'(cfg.crop_left);
    assign top_w  = CALC_BITS'(cfg.crop_top);
    assign cw_w   = CALC_BITS'(cfg.crop_width);
    assign ch_w   = CALC_BITS'(cfg.crop_height);

    assign col_off = col_w - left_w;
    assign row_off = row_w - top_w;

    assign col_keep = (col_w >= left_w) && (col_off < cw_w) && !col_off[0];
    assign row_keep = (row_w >= top_w)  && (row_off < ch_w) && !row_off[0];

    // last sample sits at (size-1) rounded down to even
    assign col_lastpos = left_w + ((cw_w - CALC_BITS'(1)) & ~CALC_BITS'(1));
    assign row_lastpos = top_w  + ((ch_w - CALC_BITS'(1)) & ~CALC_BITS'(1));
    assign col_last = (cw_w != '0) && (col_w == col_lastpos);
    assign row_last = (ch_w != '0) && (row_w == row_lastpos);

    assign win.keep = col_keep && row_keep;
    assign win.last = col_last && row_last;

    // line wrap at frame_width or at the coordinate limit
    assign col_inc  = col_w + CALC_BITS'(1);
    assign line_end = (col_inc >= CALC_BITS'(cfg.frame_width)) ||
                      (col_inc >= (CALC_BITS'(1) << COORD_BITS));

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (advance) begin
            if (line_end) begin
                col_next = '0;
                row_next = row + COORD_BITS'(1);
            end else begin
                col_next = col_inc[COORD_BITS-1:0];
                row_next = row;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

>>> src/rcdg_gray.sv
// RGB565 to offset grayscale conversion, combinational.
// Depends on nothing outside rcdg_pkg.
// gray = (30R + 59G + 11B) / 100, emitted as gray - 128.
module rcdg_gray
    import rcdg_pkg::*;
(
    input  logic [15:0] pixel,
    output logic [7:0]  gray_offset
);

    // ceil(2^19 / 100); floor(x * RECIP / 2^19) == x / 100 for x below 43690
    localparam logic [12:0] RECIP = 13'd5243;

    logic [7:0]  r8, g8, b8;
    logic [14:0] wsum;
    logic [27:0] prod;
    logic [7:0]  quot;

    assign r8 = {pixel[15:11], 3'b000};
    assign g8 = {pixel[10:5],  2'b00};
    assign b8 = {pixel[4:0],   3'b000};

    // max weighted sum 25036, fits 15 bits
    assign wsum = 15'(r8) * 15'd30 + 15'(g8) * 15'd59 + 15'(b8) * 15'd11;

    // divide by 100 through the reciprocal; product peaks below 2^27
    assign prod = 28'(wsum) * 28'(RECIP);
    assign quot = prod[26:19];

    assign gray_offset = quot - 8'd128;

endmodule

>>> src/rgb565_crop_decimate_gray_core.sv
// Top level of the RGB565 crop, 2:1 decimation and grayscale core.
// Depends on rcdg_pkg, rcdg_cfg_regs, rcdg_window and rcdg_gray.
//
// Usage:
//  - s_ channel: one RGB565 pixel per request in s_tdata, s_tuser high on
//    the first pixel of a frame (forces column 0, row 0).
//  - m_ channel: one signed gray byte (gray - 128) per kept pixel in m_tdata,
//    m_tlast high on the final sample of the crop window.
//  - APB port: frame_width, crop_left, crop_top, crop_width, crop_height at
//    byte addresses 0, 4, 8, 12, 16; write only while idle. pready always high.
//  - Throughput: one pixel per clock while m_tready stays high. A pixel
//    taken on s_ passes through the input register, then the result
//    register, which drives m_tvalid.
//  - Pixels outside the window or at odd offsets produce no request on m_.
//  - Reset (aresetn low, synchronous) empties both registers, zeroes the
//    position and restores the reset register values.
//  - When the receiver stalls, the result register holds; the input register
//    takes one more pixel if empty, then s_tready drops until m_tready returns.
module rgb565_crop_decimate_gray_core
    import rcdg_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // input pixel channel
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,   // [15:0] pixel_rgb565
    input  logic                  s_tuser,   // [0] frame_start
    // result channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // [7:0] gray_offset (signed)
    output logic                  m_tlast,   // window_last
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [PDATA_BITS-1:0] pwdata,
    output logic [PDATA_BITS-1:0] prdata,
    output logic                  pready
);

    cfg_t        cfg;
    win_t        win;

    // input register
    logic        in_valid_reg, in_valid_next;
    logic [15:0] in_pix_reg;
    logic        in_fs_reg;

    // result register
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_data_reg;
    logic        out_last_reg;

    logic        advance;     // input register item consumed this cycle
    logic        s_take;
    logic [7:0]  gray_offset;

    rcdg_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rcdg_window u_win (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .advance     (advance),
        .frame_start (in_fs_reg),
        .win         (win)
    );

    rcdg_gray u_gray (
        .pixel       (in_pix_reg),
        .gray_offset (gray_offset)
    );

    // item moves on when the result slot is free or being emptied
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_take   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_take) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance && win.keep) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_pix_reg <= s_tdata;
            in_fs_reg  <= s_tuser;
        end
        if (advance && win.keep) begin
            out_data_reg <= gray_offset;
            out_last_reg <= win.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule
